[rtl/core/qra_pkg.sv]
// qra_pkg: request and result types, microcode word layout and program rom
// for the quaternion rotation accumulator; no dependencies
package qra_pkg;

    // request: one quaternion and the load / compose selector
    typedef struct packed {
        logic               mode;
        logic signed [15:0] in_scalar;
        logic signed [15:0] in_vec_x;
        logic signed [15:0] in_vec_y;
        logic signed [15:0] in_vec_z;
    } in_item_t;

    // result: 3x3 rotation matrix, Q2.14
    typedef struct packed {
        logic signed [15:0] rot_00;
        logic signed [15:0] rot_01;
        logic signed [15:0] rot_02;
        logic signed [15:0] rot_10;
        logic signed [15:0] rot_11;
        logic signed [15:0] rot_12;
        logic signed [15:0] rot_20;
        logic signed [15:0] rot_21;
        logic signed [15:0] rot_22;
    } out_item_t;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_COMPOSE = 1'b1;

    localparam int ACC_W  = 36;
    localparam int PC_W   = 5;
    localparam int MTX_N  = 9;
    localparam int MIDX_W = 4;

    localparam logic signed [15:0]      Q14_ONE = 16'sd16384;
    localparam logic signed [ACC_W-1:0] Q28_ONE = 36'sd268435456;
    localparam logic signed [ACC_W-1:0] RND_HALF = 36'sd8192;

    // program entry points
    localparam logic [PC_W-1:0] PC_COMPOSE = 5'd0;
    localparam logic [PC_W-1:0] PC_MATRIX  = 5'd18;

    // multiplier operand sources
    typedef enum logic [2:0] {
        SRC_S, SRC_X, SRC_Y, SRC_Z, SRC_QS, SRC_QX, SRC_QY, SRC_QZ
    } src_t;

    // accumulator operations on the registered product
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_SET,
        ACC_ONEM,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    // write-back targets for a rounded accumulator
    typedef enum logic [3:0] {
        DST_NONE, DST_NS, DST_NX, DST_NY, DST_COMMIT,
        DST_M0, DST_M1, DST_M2, DST_M3, DST_M4, DST_M5, DST_M6, DST_M7, DST_M8
    } dst_t;

    // sequencing: advance, or wait for the result slot and retire
    typedef enum logic {
        SEQ_NEXT,
        SEQ_FINISH
    } seq_t;

    typedef struct packed {
        src_t    mul_a;
        src_t    mul_b;
        logic    dbl;
        acc_op_t op_a;
        acc_op_t op_b;
        dst_t    wr_a;
        dst_t    wr_b;
        seq_t    seq;
    } ctrl_word_t;

    function automatic ctrl_word_t uw(input src_t a, input src_t b, input logic dbl,
                                      input acc_op_t oa, input acc_op_t ob,
                                      input dst_t wa, input dst_t wb, input seq_t sq);
        ctrl_word_t w;
        w.mul_a = a;
        w.mul_b = b;
        w.dbl   = dbl;
        w.op_a  = oa;
        w.op_b  = ob;
        w.wr_a  = wa;
        w.wr_b  = wb;
        w.seq   = sq;
        return w;
    endfunction

    // program: a product issued at one step is accumulated at the step after it,
    // an accumulator is rounded and written at the step after its last update
    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            // compose: new scalar
            5'd0:  w = uw(SRC_S,  SRC_QS, 1'b0, ACC_HOLD, ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            5'd1:  w = uw(SRC_X,  SRC_QX, 1'b0, ACC_SET,  ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            5'd2:  w = uw(SRC_Y,  SRC_QY, 1'b0, ACC_SUB,  ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            5'd3:  w = uw(SRC_Z,  SRC_QZ, 1'b0, ACC_SUB,  ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            // compose: new x
            5'd4:  w = uw(SRC_QX, SRC_S,  1'b0, ACC_SUB,  ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            5'd5:  w = uw(SRC_X,  SRC_QS, 1'b0, ACC_SET,  ACC_HOLD, DST_NS,   DST_NONE, SEQ_NEXT);
            5'd6:  w = uw(SRC_Y,  SRC_QZ, 1'b0, ACC_ADD,  ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            5'd7:  w = uw(SRC_Z,  SRC_QY, 1'b0, ACC_ADD,  ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            // compose: new y
            5'd8:  w = uw(SRC_QY, SRC_S,  1'b0, ACC_SUB,  ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            5'd9:  w = uw(SRC_Y,  SRC_QS, 1'b0, ACC_SET,  ACC_HOLD, DST_NX,   DST_NONE, SEQ_NEXT);
            5'd10: w = uw(SRC_Z,  SRC_QX, 1'b0, ACC_ADD,  ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            5'd11: w = uw(SRC_X,  SRC_QZ, 1'b0, ACC_ADD,  ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            // compose: new z
            5'd12: w = uw(SRC_QZ, SRC_S,  1'b0, ACC_SUB,  ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            5'd13: w = uw(SRC_Z,  SRC_QS, 1'b0, ACC_SET,  ACC_HOLD, DST_NY,   DST_NONE, SEQ_NEXT);
            5'd14: w = uw(SRC_X,  SRC_QY, 1'b0, ACC_ADD,  ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            5'd15: w = uw(SRC_Y,  SRC_QX, 1'b0, ACC_ADD,  ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            5'd16: w = uw(SRC_S,  SRC_S,  1'b0, ACC_SUB,  ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            5'd17: w = uw(SRC_S,  SRC_S,  1'b0, ACC_HOLD, ACC_HOLD, DST_COMMIT, DST_NONE,
                          SEQ_NEXT);
            // matrix: off-diagonal pairs share their products
            5'd18: w = uw(SRC_X,  SRC_Y,  1'b1, ACC_HOLD, ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            5'd19: w = uw(SRC_Z,  SRC_S,  1'b1, ACC_SET,  ACC_SET,  DST_NONE, DST_NONE, SEQ_NEXT);
            5'd20: w = uw(SRC_Z,  SRC_X,  1'b1, ACC_SUB,  ACC_ADD,  DST_NONE, DST_NONE, SEQ_NEXT);
            5'd21: w = uw(SRC_Y,  SRC_S,  1'b1, ACC_SET,  ACC_SET,  DST_M1,   DST_M3,   SEQ_NEXT);
            5'd22: w = uw(SRC_Y,  SRC_Z,  1'b1, ACC_ADD,  ACC_SUB,  DST_NONE, DST_NONE, SEQ_NEXT);
            5'd23: w = uw(SRC_X,  SRC_S,  1'b1, ACC_SET,  ACC_SET,  DST_M2,   DST_M6,   SEQ_NEXT);
            5'd24: w = uw(SRC_Y,  SRC_Y,  1'b1, ACC_SUB,  ACC_ADD,  DST_NONE, DST_NONE, SEQ_NEXT);
            // matrix: diagonal
            5'd25: w = uw(SRC_Z,  SRC_Z,  1'b1, ACC_ONEM, ACC_ONEM, DST_M5,   DST_M7,   SEQ_NEXT);
            5'd26: w = uw(SRC_X,  SRC_X,  1'b1, ACC_SUB,  ACC_HOLD, DST_NONE, DST_NONE, SEQ_NEXT);
            5'd27: w = uw(SRC_Z,  SRC_Z,  1'b1, ACC_ONEM, ACC_SUB,  DST_M0,   DST_NONE, SEQ_NEXT);
            5'd28: w = uw(SRC_S,  SRC_S,  1'b1, ACC_SUB,  ACC_HOLD, DST_NONE, DST_M8,   SEQ_NEXT);
            5'd29: w = uw(SRC_S,  SRC_S,  1'b0, ACC_HOLD, ACC_HOLD, DST_M4,   DST_NONE, SEQ_NEXT);
            default: w = uw(SRC_S, SRC_S, 1'b0, ACC_HOLD, ACC_HOLD, DST_NONE, DST_NONE,
                            SEQ_FINISH);
        endcase
        return w;
    endfunction

    // Q8.28 sum to Q2.14: add half, floor shift, saturate
    function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0]  t;
        logic signed [ACC_W-15:0] r;
        logic signed [15:0]       res;
        t = v + RND_HALF;
        r = t[ACC_W-1:14];
        if (r > 22'sd32767)
            res = 16'sh7fff;
        else if (r < -22'sd32768)
            res = 16'sh8000;
        else
            res = r[15:0];
        return res;
    endfunction

endpackage

[rtl/core/quaternion_rotation_accumulator.sv]
// quaternion_rotation_accumulator: microcoded orientation update and
// rotation matrix build around one shared 16x16 multiplier
// a load request runs the matrix program; a compose request runs the compose
// program and then the matrix program; one request at a time, set by the
//   single multiplier stepping through the program rom, one product a cycle
// a request is taken while an earlier result still waits in the output register
// reset: asynchronous active low; orientation returns to identity, no result pending
// depends on qra_pkg
module quaternion_rotation_accumulator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  qra_pkg::in_item_t  cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output qra_pkg::out_item_t res
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                    state_reg;
    logic [qra_pkg::PC_W-1:0]  pc_reg;
    logic                      res_valid_reg;
    qra_pkg::out_item_t        res_reg;

    // orientation state
    logic signed [15:0] s_reg, x_reg, y_reg, z_reg;
    // operand copy of the request and composed temporaries
    logic signed [15:0] qs_reg, qx_reg, qy_reg, qz_reg;
    logic signed [15:0] ns_reg, nx_reg, ny_reg;

    logic signed [31:0]                prod_reg;
    logic signed [qra_pkg::ACC_W-1:0]  acc_a_reg, acc_b_reg;
    logic signed [qra_pkg::ACC_W-1:0]  acc_a_next, acc_b_next;
    logic signed [15:0]                mtx_reg [qra_pkg::MTX_N];

    qra_pkg::ctrl_word_t               cw;
    logic signed [15:0]                opa, opb;
    logic signed [32:0]                p33;
    logic signed [qra_pkg::ACC_W-1:0]  addend;
    logic signed [15:0]                rnd_a, rnd_b;
    logic                              accept, running, finish_go, res_taken;

    // control word fetch
    assign cw = qra_pkg::ucode_rom(pc_reg);

    assign running   = (state_reg == ST_RUN);
    assign accept    = cmd_valid && (state_reg == ST_IDLE);
    assign res_taken = res_valid_reg && !res_stall;
    assign finish_go = running && (cw.seq == qra_pkg::SEQ_FINISH)
                       && (!res_valid_reg || !res_stall);

    assign cmd_stall = running;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    function automatic logic signed [15:0] pick(
        input qra_pkg::src_t sel,
        input logic signed [15:0] s, x, y, z, qs, qx, qy, qz);
        logic signed [15:0] v;
        case (sel)
            qra_pkg::SRC_S:  v = s;
            qra_pkg::SRC_X:  v = x;
            qra_pkg::SRC_Y:  v = y;
            qra_pkg::SRC_Z:  v = z;
            qra_pkg::SRC_QS: v = qs;
            qra_pkg::SRC_QX: v = qx;
            qra_pkg::SRC_QY: v = qy;
            qra_pkg::SRC_QZ: v = qz;
            default:         v = s;
        endcase
        return v;
    endfunction

    function automatic logic signed [qra_pkg::ACC_W-1:0] acc_step(
        input qra_pkg::acc_op_t op,
        input logic signed [qra_pkg::ACC_W-1:0] acc,
        input logic signed [qra_pkg::ACC_W-1:0] p);
        logic signed [qra_pkg::ACC_W-1:0] v;
        case (op)
            qra_pkg::ACC_HOLD: v = acc;
            qra_pkg::ACC_SET:  v = p;
            qra_pkg::ACC_ONEM: v = qra_pkg::Q28_ONE - p;
            qra_pkg::ACC_ADD:  v = acc + p;
            qra_pkg::ACC_SUB:  v = acc - p;
            default:           v = acc;
        endcase
        return v;
    endfunction

    // operand selection and accumulator update
    always_comb
    begin
        opa        = pick(cw.mul_a, s_reg, x_reg, y_reg, z_reg,
                          qs_reg, qx_reg, qy_reg, qz_reg);
        opb        = pick(cw.mul_b, s_reg, x_reg, y_reg, z_reg,
                          qs_reg, qx_reg, qy_reg, qz_reg);
        p33        = cw.dbl ? $signed({prod_reg, 1'b0}) : 33'(prod_reg);
        addend     = qra_pkg::ACC_W'(p33);
        acc_a_next = acc_step(cw.op_a, acc_a_reg, addend);
        acc_b_next = acc_step(cw.op_b, acc_b_reg, addend);
        rnd_a      = qra_pkg::round_sat(acc_a_reg);
        rnd_b      = qra_pkg::round_sat(acc_b_reg);
    end

    // sequencer, orientation state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= qra_pkg::PC_COMPOSE;
            res_valid_reg <= 1'b0;
            s_reg         <= qra_pkg::Q14_ONE;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_RUN;
                        if (cmd.mode == qra_pkg::MODE_LOAD)
                        begin
                            pc_reg <= qra_pkg::PC_MATRIX;
                            s_reg  <= cmd.in_scalar;
                            x_reg  <= cmd.in_vec_x;
                            y_reg  <= cmd.in_vec_y;
                            z_reg  <= cmd.in_vec_z;
                        end
                        else
                        begin
                            pc_reg <= qra_pkg::PC_COMPOSE;
                        end
                    end
                end
                ST_RUN:
                begin
                    if (cw.wr_a == qra_pkg::DST_COMMIT)
                    begin
                        s_reg <= ns_reg;
                        x_reg <= nx_reg;
                        y_reg <= ny_reg;
                        z_reg <= rnd_a;
                    end
                    if (cw.seq == qra_pkg::SEQ_NEXT)
                    begin
                        pc_reg <= pc_reg + 1'b1;
                    end
                    else if (finish_go)
                    begin
                        state_reg     <= ST_IDLE;
                        res_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // result slot empties when taken, unless refilled on the same edge
            if (res_taken && !finish_go)
                res_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qs_reg <= cmd.in_scalar;
            qx_reg <= cmd.in_vec_x;
            qy_reg <= cmd.in_vec_y;
            qz_reg <= cmd.in_vec_z;
        end
        prod_reg  <= opa * opb;
        acc_a_reg <= acc_a_next;
        acc_b_reg <= acc_b_next;
        if (running)
        begin
            case (cw.wr_a)
                qra_pkg::DST_NS: ns_reg <= rnd_a;
                qra_pkg::DST_NX: nx_reg <= rnd_a;
                qra_pkg::DST_NY: ny_reg <= rnd_a;
                default: ;
            endcase
            if (cw.wr_a >= qra_pkg::DST_M0)
                mtx_reg[qra_pkg::MIDX_W'(cw.wr_a - qra_pkg::DST_M0)] <= rnd_a;
            if (cw.wr_b >= qra_pkg::DST_M0)
                mtx_reg[qra_pkg::MIDX_W'(cw.wr_b - qra_pkg::DST_M0)] <= rnd_b;
        end
        if (finish_go)
        begin
            res_reg.rot_00 <= mtx_reg[0];
            res_reg.rot_01 <= mtx_reg[1];
            res_reg.rot_02 <= mtx_reg[2];
            res_reg.rot_10 <= mtx_reg[3];
            res_reg.rot_11 <= mtx_reg[4];
            res_reg.rot_12 <= mtx_reg[5];
            res_reg.rot_20 <= mtx_reg[6];
            res_reg.rot_21 <= mtx_reg[7];
            res_reg.rot_22 <= mtx_reg[8];
        end
    end

endmodule

[rtl/core/qra_checker.sv]
// qra_checker: port-level assertions for the quaternion rotation accumulator
// and the bind that attaches them; depends on qra_pkg
module qra_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input qra_pkg::in_item_t  cmd,
    input logic               res_valid,
    input logic               res_stall,
    input qra_pkg::out_item_t res
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

    // a stalled request holds
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
        else $error("stalled request changed");

    // one request at a time: taking a request blocks the next
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("request port open right after a request");

    // a new result only appears at the end of a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_stall) && !cmd_stall)
        else $error("result appeared without a request in progress");

    // the block goes idle only by handing over a result
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(cmd_stall) |-> res_valid)
        else $error("request finished without a result");

endmodule

bind quaternion_rotation_accumulator qra_checker u_qra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
